FILE: sv/nfcgt_pkg.sv
`timescale 1ns / 1ps

package nfcgt_pkg;

    // Counter and field widths
    localparam int CNT_W       = 16;
    localparam int TIMER_COUNT = 2;
    localparam int HZ_W        = 27;
    localparam int TV_W        = 32;
    localparam int COMP_W      = 17;
    localparam int AMT_W       = TV_W + 1;
    localparam int TICK_W      = HZ_W + AMT_W;
    localparam int DEN_W       = (CNT_W + 1 > 24) ? CNT_W + 1 : 24;
    localparam int STEP_W      = $clog2(TICK_W + 1);

    localparam int FC_HZ    = 13560000;
    localparam int US_PER_S = 1000000;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [HZ_W-1:0]  HZ_RESET = HZ_W'(64000000);

    // Input commands
    localparam logic [2:0] CMD_TICK         = 3'd0;
    localparam logic [2:0] CMD_FWT_START_FC = 3'd1;
    localparam logic [2:0] CMD_FWT_STOP     = 3'd2;
    localparam logic [2:0] CMD_TX_START_FC  = 3'd3;
    localparam logic [2:0] CMD_TX_START_US  = 3'd4;
    localparam logic [2:0] CMD_TX_STOP      = 3'd5;

    // Fault codes
    localparam logic [1:0] FLT_NONE    = 2'd0;
    localparam logic [1:0] FLT_NOT_EN  = 2'd1;
    localparam logic [1:0] FLT_RUNNING = 2'd2;
    localparam logic [1:0] FLT_DELAY   = 2'd3;

    // NFC modes
    localparam logic [1:0] MODE_POLLER   = 2'd1;
    localparam logic [1:0] MODE_LISTENER = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_MODE      = 3'd1;
    localparam logic [2:0] REG_PFWT_COMP = 3'd2;
    localparam logic [2:0] REG_PFDT_COMP = 3'd3;
    localparam logic [2:0] REG_LFDT_COMP = 3'd4;
    localparam logic [2:0] REG_CORE_HZ   = 3'd5;

    typedef struct packed {
        logic             start;
        logic             use_us;
        logic [HZ_W-1:0]  hz;
        logic [AMT_W-1:0] amount;
    } calc_req_t;

    typedef struct packed {
        logic             done;
        logic             bad_delay;
        logic [CNT_W-1:0] psc;
        logic [CNT_W-1:0] arr;
    } calc_res_t;

endpackage

FILE: sv/nfcgt_delay_calc.sv
`timescale 1ns / 1ps

module nfcgt_delay_calc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  nfcgt_pkg::calc_req_t req,
    output nfcgt_pkg::calc_res_t res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_HZDIV = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_TDIV  = 3'd3;
    localparam logic [2:0] ST_CHK   = 3'd4;
    localparam logic [2:0] ST_PDIV  = 3'd5;
    localparam logic [2:0] ST_ADIV  = 3'd6;

    localparam int TICK_W = nfcgt_pkg::TICK_W;
    localparam int AMT_W  = nfcgt_pkg::AMT_W;
    localparam int HZ_W   = nfcgt_pkg::HZ_W;
    localparam int DEN_W  = nfcgt_pkg::DEN_W;
    localparam int CNT_W  = nfcgt_pkg::CNT_W;
    localparam int STEP_W = nfcgt_pkg::STEP_W;

    localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(TICK_W);
    localparam logic [STEP_W-1:0] MUL_STEPS = STEP_W'(AMT_W);
    localparam logic [DEN_W-1:0]  DEN_FC    = DEN_W'(nfcgt_pkg::FC_HZ);
    localparam logic [DEN_W-1:0]  DEN_US    = DEN_W'(nfcgt_pkg::US_PER_S);
    localparam logic [DEN_W-1:0]  DEN_CMAX  = DEN_W'(nfcgt_pkg::CNT_MAX);
    localparam logic [CNT_W:0]    PSC_ONE   = (CNT_W + 1)'(1);

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              use_us_reg, use_us_next;
    logic [HZ_W-1:0]   mcand_reg, mcand_next;
    logic [AMT_W-1:0]  mplier_reg, mplier_next;
    logic [TICK_W-1:0] acc_reg, acc_next;
    logic [TICK_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [CNT_W-1:0]  psc_reg, psc_next;
    logic              done_reg, done_next;
    logic              bad_reg, bad_next;
    logic [CNT_W-1:0]  rpsc_reg, rpsc_next;
    logic [CNT_W-1:0]  rarr_reg, rarr_next;

    logic [HZ_W:0]     mul_sum;
    logic [TICK_W-1:0] acc_step;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              fits;
    logic [DEN_W-1:0]  rem_step;
    logic [TICK_W-1:0] num_step;
    logic              div_done;

    // One multiplier bit per cycle: add into the top and shift right
    assign mul_sum  = {1'b0, acc_reg[TICK_W-1:AMT_W]}
                    + (mplier_reg[0] ? {1'b0, mcand_reg} : {(HZ_W + 1){1'b0}});
    assign acc_step = {mul_sum, acc_reg[AMT_W-1:1]};

    // One quotient bit per cycle, restoring division
    assign trial     = {rem_reg, num_reg[TICK_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign fits      = (trial >= {1'b0, den_reg});
    assign rem_step  = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
    assign num_step  = {num_reg[TICK_W-2:0], fits};
    assign div_done  = (step_reg == DIV_STEPS);

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        use_us_next = use_us_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        psc_next    = psc_reg;
        done_next   = 1'b0;
        bad_next    = bad_reg;
        rpsc_next   = rpsc_reg;
        rarr_next   = rarr_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    use_us_next = req.use_us;
                    mplier_next = req.amount;
                    step_next   = '0;
                    acc_next    = '0;
                    if (req.use_us) begin
                        num_next   = TICK_W'(req.hz);
                        rem_next   = '0;
                        den_next   = DEN_US;
                        state_next = ST_HZDIV;
                    end else begin
                        mcand_next = req.hz;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_HZDIV: begin
                if (!div_done) begin
                    step_next = step_reg + STEP_W'(1);
                    num_next  = num_step;
                    rem_next  = rem_step;
                end else begin
                    mcand_next = num_reg[HZ_W-1:0];
                    acc_next   = '0;
                    step_next  = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (step_reg != MUL_STEPS) begin
                    step_next   = step_reg + STEP_W'(1);
                    acc_next    = acc_step;
                    mplier_next = mplier_reg >> 1;
                end else if (use_us_reg) begin
                    state_next = ST_CHK;
                end else begin
                    num_next   = acc_reg;
                    rem_next   = '0;
                    den_next   = DEN_FC;
                    step_next  = '0;
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV: begin
                if (!div_done) begin
                    step_next = step_reg + STEP_W'(1);
                    num_next  = num_step;
                    rem_next  = rem_step;
                end else begin
                    acc_next   = num_reg;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                // acc holds the delay in core ticks from here on
                if (acc_reg == '0) begin
                    done_next  = 1'b1;
                    bad_next   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    num_next   = acc_reg - TICK_W'(1);
                    rem_next   = '0;
                    den_next   = DEN_CMAX;
                    step_next  = '0;
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (!div_done) begin
                    step_next = step_reg + STEP_W'(1);
                    num_next  = num_step;
                    rem_next  = rem_step;
                end else if (|num_reg[TICK_W-1:CNT_W]) begin
                    done_next  = 1'b1;
                    bad_next   = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    psc_next   = num_reg[CNT_W-1:0];
                    num_next   = acc_reg;
                    rem_next   = '0;
                    den_next   = DEN_W'({1'b0, num_reg[CNT_W-1:0]} + PSC_ONE);
                    step_next  = '0;
                    state_next = ST_ADIV;
                end
            end
            ST_ADIV: begin
                if (!div_done) begin
                    step_next = step_reg + STEP_W'(1);
                    num_next  = num_step;
                    rem_next  = rem_step;
                end else begin
                    done_next  = 1'b1;
                    bad_next   = |num_reg[TICK_W-1:CNT_W];
                    rpsc_next  = psc_reg;
                    rarr_next  = num_reg[CNT_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        use_us_reg <= use_us_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        psc_reg    <= psc_next;
        bad_reg    <= bad_next;
        rpsc_reg   <= rpsc_next;
        rarr_reg   <= rarr_next;
    end

    assign res.done      = done_reg;
    assign res.bad_delay = bad_reg;
    assign res.psc       = rpsc_reg;
    assign res.arr       = rarr_reg;

    a_start_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (state_reg == ST_IDLE))
        else $error("conversion start while busy");

    a_done_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (state_reg == ST_IDLE) && !$past(req.start))
        else $error("result pulse outside end of conversion");

    a_den_nonzero : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HZDIV || state_reg == ST_TDIV || state_reg == ST_PDIV
         || state_reg == ST_ADIV) |-> (den_reg != '0))
        else $error("division by zero");

    a_mul_steps : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |-> (step_reg <= MUL_STEPS))
        else $error("multiply step count overrun");

endmodule

FILE: sv/nfc_guard_time_timers.sv
`timescale 1ns / 1ps
// Tick, stop, undefined and rejected commands: result registered in the cycle after the transfer,
// one item per cycle while the output buffer is not full. Starts that need a conversion stall
// the input until the result (bit-serial multiply of 33 steps plus up to three 60-step restoring
// divisions in nfcgt_delay_calc); no item is taken meanwhile. Results sit in a two-entry output
// buffer. Reset (aresetn low, synchronous) stops both timers, clears counters and the buffer,
// and returns the registers to their reset values.

module nfc_guard_time_timers (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // [31:0] time_value
    input  logic [2:0]  s_tuser,  // [2:0] command
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [0] fwt_expired, [1] tx_expired, [2] fwt_running,
                                  // [3] tx_running, [5:4] fault, [7:6] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NT     = nfcgt_pkg::TIMER_COUNT;
    localparam int CNT_W  = nfcgt_pkg::CNT_W;
    localparam int COMP_W = nfcgt_pkg::COMP_W;
    localparam int HZ_W   = nfcgt_pkg::HZ_W;
    localparam int TV_W   = nfcgt_pkg::TV_W;
    localparam int AMT_W  = nfcgt_pkg::AMT_W;
    localparam int CMP_W  = TV_W + 2;

    // configuration registers
    logic              en_reg;
    logic [1:0]        mode_reg;
    logic [COMP_W-1:0] pfwt_reg, pfdt_reg, lfdt_reg;
    logic [HZ_W-1:0]   hz_reg;

    // timer state
    logic             run_reg      [NT];
    logic             run_next     [NT];
    logic [CNT_W-1:0] psc_cnt_reg  [NT];
    logic [CNT_W-1:0] psc_cnt_next [NT];
    logic [CNT_W-1:0] main_cnt_reg [NT];
    logic [CNT_W-1:0] main_cnt_next[NT];
    logic [CNT_W-1:0] psc_val_reg  [NT];
    logic [CNT_W-1:0] psc_val_next [NT];
    logic [CNT_W-1:0] rld_val_reg  [NT];
    logic [CNT_W-1:0] rld_val_next [NT];
    logic             expired      [NT];

    logic busy_reg, busy_next;
    logic sel_reg, sel_next;

    // output buffer
    logic       out_valid_reg, skid_valid_reg;
    logic [7:0] out_data_reg, skid_data_reg;
    logic       push, pop;
    logic [7:0] push_data;
    logic [1:0] fault;

    logic                 accept;
    logic [2:0]           cmd;
    logic                 tsel;
    logic [COMP_W-1:0]    comp;
    logic [CMP_W-1:0]     comp_ext, tv_ext, diff;
    logic                 skip;
    logic                 cfg_we;

    nfcgt_pkg::calc_req_t calc_req;
    nfcgt_pkg::calc_res_t calc_res;

    assign cmd      = s_tuser;
    assign s_tready = !busy_reg && !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign tsel     = (cmd != nfcgt_pkg::CMD_FWT_START_FC) && (cmd != nfcgt_pkg::CMD_FWT_STOP);

    // compensation for the timer named by the command
    always_comb begin
        comp = '0;
        if (mode_reg == nfcgt_pkg::MODE_POLLER) begin
            comp = tsel ? pfdt_reg : pfwt_reg;
        end else if (mode_reg == nfcgt_pkg::MODE_LISTENER && tsel) begin
            comp = lfdt_reg;
        end
    end

    assign comp_ext = {{(CMP_W - COMP_W){comp[COMP_W-1]}}, comp};
    assign tv_ext   = {2'b00, s_tdata};
    assign skip     = ($signed(comp_ext) >= $signed(tv_ext));
    assign diff     = tv_ext - comp_ext;

    always_comb begin
        run_next      = run_reg;
        psc_cnt_next  = psc_cnt_reg;
        main_cnt_next = main_cnt_reg;
        psc_val_next  = psc_val_reg;
        rld_val_next  = rld_val_reg;
        busy_next     = busy_reg;
        sel_next      = sel_reg;
        push          = 1'b0;
        fault         = nfcgt_pkg::FLT_NONE;
        calc_req      = '0;
        calc_req.hz   = hz_reg;
        for (int t = 0; t < NT; t++) begin
            expired[t] = 1'b0;
        end

        if (accept) begin
            push = 1'b1;
            case (cmd)
                nfcgt_pkg::CMD_TICK: begin
                    for (int t = 0; t < NT; t++) begin
                        if (run_reg[t]) begin
                            if (psc_cnt_reg[t] != psc_val_reg[t]) begin
                                psc_cnt_next[t] = psc_cnt_reg[t] + CNT_W'(1);
                            end else begin
                                psc_cnt_next[t] = '0;
                                if (main_cnt_reg[t] != rld_val_reg[t]) begin
                                    main_cnt_next[t] = main_cnt_reg[t] + CNT_W'(1);
                                end else begin
                                    main_cnt_next[t] = '0;
                                    run_next[t]      = 1'b0;
                                    expired[t]       = 1'b1;
                                end
                            end
                        end
                    end
                end
                nfcgt_pkg::CMD_FWT_START_FC, nfcgt_pkg::CMD_TX_START_FC: begin
                    if (!en_reg) begin
                        fault = nfcgt_pkg::FLT_NOT_EN;
                    end else if (skip) begin
                        fault = nfcgt_pkg::FLT_NONE;
                    end else if (run_reg[tsel]) begin
                        fault = nfcgt_pkg::FLT_RUNNING;
                    end else begin
                        push            = 1'b0;
                        busy_next       = 1'b1;
                        sel_next        = tsel;
                        calc_req.start  = 1'b1;
                        calc_req.amount = diff[AMT_W-1:0];
                    end
                end
                nfcgt_pkg::CMD_TX_START_US: begin
                    if (!en_reg) begin
                        fault = nfcgt_pkg::FLT_NOT_EN;
                    end else if (run_reg[1]) begin
                        fault = nfcgt_pkg::FLT_RUNNING;
                    end else begin
                        push            = 1'b0;
                        busy_next       = 1'b1;
                        sel_next        = 1'b1;
                        calc_req.start  = 1'b1;
                        calc_req.use_us = 1'b1;
                        calc_req.amount = {1'b0, s_tdata};
                    end
                end
                nfcgt_pkg::CMD_FWT_STOP, nfcgt_pkg::CMD_TX_STOP: begin
                    if (!en_reg) begin
                        fault = nfcgt_pkg::FLT_NOT_EN;
                    end else begin
                        run_next[tsel]      = 1'b0;
                        psc_cnt_next[tsel]  = '0;
                        main_cnt_next[tsel] = '0;
                        rld_val_next[tsel]  = '0;
                    end
                end
                default: begin
                    fault = nfcgt_pkg::FLT_NONE;
                end
            endcase
        end

        // load the timer, or report a delay fault, once the conversion finishes
        if (calc_res.done) begin
            push      = 1'b1;
            busy_next = 1'b0;
            if (calc_res.bad_delay) begin
                fault = nfcgt_pkg::FLT_DELAY;
            end else begin
                psc_val_next[sel_reg]  = calc_res.psc;
                rld_val_next[sel_reg]  = calc_res.arr;
                psc_cnt_next[sel_reg]  = '0;
                main_cnt_next[sel_reg] = '0;
                run_next[sel_reg]      = 1'b1;
            end
        end
    end

    assign push_data = {2'b00, fault, run_next[1], run_next[0], expired[1], expired[0]};

    nfcgt_delay_calc u_calc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (calc_req),
        .res     (calc_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            sel_reg  <= 1'b0;
            for (int t = 0; t < NT; t++) begin
                run_reg[t]      <= 1'b0;
                psc_cnt_reg[t]  <= '0;
                main_cnt_reg[t] <= '0;
                psc_val_reg[t]  <= '0;
                rld_val_reg[t]  <= '0;
            end
        end else begin
            busy_reg     <= busy_next;
            sel_reg      <= sel_next;
            run_reg      <= run_next;
            psc_cnt_reg  <= psc_cnt_next;
            main_cnt_reg <= main_cnt_next;
            psc_val_reg  <= psc_val_next;
            rld_val_reg  <= rld_val_next;
        end
    end

    // two-entry result buffer
    assign pop = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (skid_valid_reg) begin
                    out_data_reg   <= skid_data_reg;
                    skid_data_reg  <= push_data;
                    skid_valid_reg <= push;
                end else begin
                    out_data_reg  <= push_data;
                    out_valid_reg <= push;
                end
            end else if (push) begin
                if (!out_valid_reg) begin
                    out_data_reg  <= push_data;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_data_reg  <= push_data;
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= 1'b0;
            mode_reg <= 2'b00;
            pfwt_reg <= '0;
            pfdt_reg <= '0;
            lfdt_reg <= '0;
            hz_reg   <= nfcgt_pkg::HZ_RESET;
        end else if (cfg_we) begin
            case (paddr[4:2])
                nfcgt_pkg::REG_ENABLE:    en_reg   <= pwdata[0];
                nfcgt_pkg::REG_MODE:      mode_reg <= pwdata[1:0];
                nfcgt_pkg::REG_PFWT_COMP: pfwt_reg <= pwdata[COMP_W-1:0];
                nfcgt_pkg::REG_PFDT_COMP: pfdt_reg <= pwdata[COMP_W-1:0];
                nfcgt_pkg::REG_LFDT_COMP: lfdt_reg <= pwdata[COMP_W-1:0];
                nfcgt_pkg::REG_CORE_HZ:   hz_reg   <= pwdata[HZ_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            nfcgt_pkg::REG_ENABLE:    prdata = {31'd0, en_reg};
            nfcgt_pkg::REG_MODE:      prdata = {30'd0, mode_reg};
            nfcgt_pkg::REG_PFWT_COMP: prdata = {{(32 - COMP_W){1'b0}}, pfwt_reg};
            nfcgt_pkg::REG_PFDT_COMP: prdata = {{(32 - COMP_W){1'b0}}, pfdt_reg};
            nfcgt_pkg::REG_LFDT_COMP: prdata = {{(32 - COMP_W){1'b0}}, lfdt_reg};
            nfcgt_pkg::REG_CORE_HZ:   prdata = {{(32 - HZ_W){1'b0}}, hz_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    a_busy_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !s_tready)
        else $error("transfer taken during conversion");

    a_skid_order : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without head entry");

    a_done_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        calc_res.done |-> busy_reg)
        else $error("conversion result with no start pending");

    a_fwt_counts : assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg[0] |-> (psc_cnt_reg[0] <= psc_val_reg[0])
                       && (main_cnt_reg[0] <= rld_val_reg[0]))
        else $error("frame-wait counter past its limit");

    a_tx_counts : assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg[1] |-> (psc_cnt_reg[1] <= psc_val_reg[1])
                       && (main_cnt_reg[1] <= rld_val_reg[1]))
        else $error("block-transmit counter past its limit");

endmodule
